// ===== sv/robin_hood_hash_map_assert.svh =====
`ifndef ROBIN_HOOD_HASH_MAP_ASSERT_SVH
`define ROBIN_HOOD_HASH_MAP_ASSERT_SVH

// same-cycle implication, checked at every rising edge outside reset
`define RHH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RHH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rhh_pkg.sv =====
package rhh_pkg;

    localparam int SLOTS      = 1024;
    localparam int SLOT_BITS  = $clog2(SLOTS);
    localparam int CNT_W      = SLOT_BITS + 1;
    localparam int VALUE_BITS = 64;
    localparam int WORD_BITS  = 64;
    localparam int KEY_BITS   = 4 * WORD_BITS;
    localparam int OCC_W      = 11;
    localparam int HALF_BITS  = WORD_BITS / 2;
    localparam int MIX_SHIFT  = 33;

    localparam logic [WORD_BITS-1:0] MIX_MUL1 = 64'hff51afd7ed558ccd;
    localparam logic [WORD_BITS-1:0] MIX_MUL2 = 64'hc4ceb9fe1a85ec53;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;

    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_MISS = 2'd1;
    localparam logic [1:0] STS_FULL = 2'd2;

    typedef struct packed {
        logic                  used;
        logic [SLOT_BITS-1:0]  probe_len;
        logic [VALUE_BITS-1:0] payload;
        logic [KEY_BITS-1:0]   key;
    } t_entry;

endpackage

// ===== sv/rhh_hash.sv =====
module rhh_hash
    import rhh_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WORD_BITS-1:0] i_fold,
    output logic                 o_done,
    output logic [SLOT_BITS-1:0] o_slot
);

    logic                   r_busy, n_busy;
    logic                   r_phase, n_phase;
    logic [1:0]             r_step, n_step;
    logic                   r_done, n_done;
    logic [WORD_BITS-1:0]   r_x, n_x;
    logic [WORD_BITS-1:0]   r_acc, n_acc;
    logic [WORD_BITS-1:0]   r_prod, n_prod;
    logic [WORD_BITS-1:0]   w_mul_b;
    logic [HALF_BITS-1:0]   w_opa, w_opb;
    logic [WORD_BITS-1:0]   w_sum;

    assign w_mul_b = r_phase ? MIX_MUL2 : MIX_MUL1;
    assign w_sum   = r_acc + {r_prod[HALF_BITS-1:0], {HALF_BITS{1'b0}}};

    always_comb begin
        unique case (r_step)
            2'd0: begin w_opa = r_x[HALF_BITS-1:0];         w_opb = w_mul_b[HALF_BITS-1:0]; end
            2'd1: begin w_opa = r_x[HALF_BITS-1:0];         w_opb = w_mul_b[WORD_BITS-1:HALF_BITS]; end
            2'd2: begin w_opa = r_x[WORD_BITS-1:HALF_BITS]; w_opb = w_mul_b[HALF_BITS-1:0]; end
            default: begin w_opa = r_x[HALF_BITS-1:0];      w_opb = w_mul_b[HALF_BITS-1:0]; end
        endcase
    end

    always_comb begin
        n_busy  = r_busy;
        n_phase = r_phase;
        n_step  = r_step;
        n_done  = 1'b0;
        n_x     = r_x;
        n_acc   = r_acc;
        n_prod  = WORD_BITS'(w_opa) * WORD_BITS'(w_opb);
        if (!r_busy) begin
            if (i_start) begin
                n_x     = i_fold ^ (i_fold >> MIX_SHIFT);
                n_busy  = 1'b1;
                n_phase = 1'b0;
                n_step  = 2'd0;
            end
        end else begin
            unique case (r_step)
                2'd0: n_step = 2'd1;
                2'd1: begin
                    n_acc  = r_prod;
                    n_step = 2'd2;
                end
                2'd2: begin
                    n_acc  = w_sum;
                    n_step = 2'd3;
                end
                default: begin
                    n_x    = w_sum ^ (w_sum >> MIX_SHIFT);
                    n_step = 2'd0;
                    if (r_phase) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end else begin
                        n_phase = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_step  <= 2'd0;
            r_done  <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_phase <= n_phase;
            r_step  <= n_step;
            r_done  <= n_done;
        end
        r_x    <= n_x;
        r_acc  <= n_acc;
        r_prod <= n_prod;
    end

    assign o_done = r_done;
    assign o_slot = r_x[SLOT_BITS-1:0];

endmodule

// ===== sv/robin_hood_hash_map.sv =====
// Robin Hood hash map, 1024 slots, 256-bit keys, 64-bit payloads. A request is
// taken when start is high and busy is low; exactly one result follows, shown
// for one cycle with o_done high, and must be captured then. After reset the
// block clears its table (busy high). A request is then hashed on one shared
// 32x32 multiplier; each slot probed on the single-port table memory, and each
// slot moved during insert displacement or delete back-shift, takes a read
// state and a check state, and a response state ends the request.
`include "robin_hood_hash_map_assert.svh"

module robin_hood_hash_map
    import rhh_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_req_type,
    input  logic [WORD_BITS-1:0]  i_key_word0,
    input  logic [WORD_BITS-1:0]  i_key_word1,
    input  logic [WORD_BITS-1:0]  i_key_word2,
    input  logic [WORD_BITS-1:0]  i_key_word3,
    input  logic [WORD_BITS-1:0]  i_new_value,
    output logic                  o_done,
    output logic [1:0]            o_status,
    output logic [WORD_BITS-1:0]  o_found_value,
    output logic [OCC_W-1:0]      o_occupancy
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HASH  = 4'd2;
    localparam logic [3:0] S_FRD   = 4'd3;
    localparam logic [3:0] S_FCHK  = 4'd4;
    localparam logic [3:0] S_IRD   = 4'd5;
    localparam logic [3:0] S_ICHK  = 4'd6;
    localparam logic [3:0] S_DRD   = 4'd7;
    localparam logic [3:0] S_DCHK  = 4'd8;
    localparam logic [3:0] S_RESP  = 4'd9;

    t_entry                r_mem [SLOTS];
    t_entry                r_rd;
    logic                  w_rd_en;
    logic [SLOT_BITS-1:0]  w_rd_addr;
    logic                  w_wr_en;
    logic [SLOT_BITS-1:0]  w_wr_addr;
    t_entry                w_wr_data;

    logic [3:0]            r_state, n_state;
    logic [1:0]            r_req, n_req;
    logic [KEY_BITS-1:0]   r_ck, n_ck;
    logic [VALUE_BITS-1:0] r_cv, n_cv;
    logic [SLOT_BITS-1:0]  r_p, n_p;
    logic [SLOT_BITS-1:0]  r_home, n_home;
    logic [CNT_W-1:0]      r_d, n_d;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [SLOT_BITS-1:0]  r_clr, n_clr;
    logic [1:0]            r_status, n_status;
    logic [VALUE_BITS-1:0] r_fval, n_fval;
    logic                  r_done, n_done;
    logic [OCC_W-1:0]      r_occ, n_occ;

    logic                  w_hash_start;
    logic                  w_hash_done;
    logic [SLOT_BITS-1:0]  w_hash_slot;
    logic [SLOT_BITS-1:0]  w_p_next;

    rhh_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hash_start),
        .i_fold  (i_key_word0 ^ i_key_word1 ^ i_key_word2 ^ i_key_word3),
        .o_done  (w_hash_done),
        .o_slot  (w_hash_slot)
    );

    assign w_p_next = (r_p == SLOT_BITS'(SLOTS - 1)) ? '0 : r_p + 1'b1;

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_ck      = r_ck;
        n_cv      = r_cv;
        n_p       = r_p;
        n_home    = r_home;
        n_d       = r_d;
        n_cnt     = r_cnt;
        n_clr     = r_clr;
        n_status  = r_status;
        n_fval    = r_fval;
        n_done    = 1'b0;
        n_occ     = r_occ;
        w_rd_en   = 1'b0;
        w_rd_addr = r_p;
        w_wr_en   = 1'b0;
        w_wr_addr = r_p;
        w_wr_data = '0;
        w_hash_start = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == SLOT_BITS'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_req    = i_req_type;
                    n_ck     = {i_key_word3, i_key_word2, i_key_word1, i_key_word0};
                    n_cv     = i_new_value[VALUE_BITS-1:0];
                    n_fval   = '0;
                    n_status = STS_MISS;
                    if (i_req_type == REQ_INSERT || i_req_type == REQ_LOOKUP ||
                        i_req_type == REQ_DELETE) begin
                        w_hash_start = 1'b1;
                        n_state      = S_HASH;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_HASH: begin
                if (w_hash_done) begin
                    n_p     = w_hash_slot;
                    n_home  = w_hash_slot;
                    n_d     = '0;
                    n_state = S_FRD;
                end
            end
            S_FRD: begin
                w_rd_en = 1'b1;
                n_state = S_FCHK;
            end
            S_FCHK: begin
                priority if (r_d == CNT_W'(SLOTS) || !r_rd.used ||
                             {1'b0, r_rd.probe_len} < r_d) begin
                    if (r_req == REQ_INSERT && r_cnt < CNT_W'(SLOTS)) begin
                        n_p     = r_home;
                        n_d     = '0;
                        n_state = S_IRD;
                    end else begin
                        n_status = (r_req == REQ_INSERT) ? STS_FULL : STS_MISS;
                        n_state  = S_RESP;
                    end
                end else if (r_rd.key == r_ck) begin
                    n_status = STS_OK;
                    if (r_req == REQ_INSERT) begin
                        w_wr_en           = 1'b1;
                        w_wr_data         = r_rd;
                        w_wr_data.payload = r_cv;
                        n_state           = S_RESP;
                    end else if (r_req == REQ_LOOKUP) begin
                        n_fval  = r_rd.payload;
                        n_state = S_RESP;
                    end else begin
                        n_d     = '0;
                        n_state = S_DRD;
                    end
                end else begin
                    n_p     = w_p_next;
                    n_d     = r_d + 1'b1;
                    n_state = S_FRD;
                end
            end
            S_IRD: begin
                w_rd_en = 1'b1;
                n_state = S_ICHK;
            end
            S_ICHK: begin
                w_wr_data.used      = 1'b1;
                w_wr_data.probe_len = r_d[SLOT_BITS-1:0];
                w_wr_data.payload   = r_cv;
                w_wr_data.key       = r_ck;
                priority if (!r_rd.used) begin
                    w_wr_en  = 1'b1;
                    n_cnt    = r_cnt + 1'b1;
                    n_status = STS_OK;
                    n_state  = S_RESP;
                end else if ({1'b0, r_rd.probe_len} < r_d) begin
                    w_wr_en = 1'b1;
                    n_ck    = r_rd.key;
                    n_cv    = r_rd.payload;
                    n_d     = {1'b0, r_rd.probe_len} + 1'b1;
                    n_p     = w_p_next;
                    n_state = S_IRD;
                end else begin
                    n_d     = r_d + 1'b1;
                    n_p     = w_p_next;
                    n_state = S_IRD;
                end
            end
            S_DRD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_p_next;
                n_state   = S_DCHK;
            end
            S_DCHK: begin
                w_wr_en = 1'b1;
                if (r_d == CNT_W'(SLOTS - 1) || !r_rd.used || r_rd.probe_len == '0) begin
                    n_cnt    = (r_cnt != '0) ? r_cnt - 1'b1 : r_cnt;
                    n_state  = S_RESP;
                end else begin
                    w_wr_data           = r_rd;
                    w_wr_data.probe_len = r_rd.probe_len - 1'b1;
                    n_p                 = w_p_next;
                    n_d                 = r_d + 1'b1;
                    n_state             = S_DRD;
                end
            end
            S_RESP: begin
                n_done  = 1'b1;
                n_occ   = OCC_W'(r_cnt);
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
        r_req    <= n_req;
        r_ck     <= n_ck;
        r_cv     <= n_cv;
        r_p      <= n_p;
        r_home   <= n_home;
        r_d      <= n_d;
        r_status <= n_status;
        r_fval   <= n_fval;
        r_occ    <= n_occ;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_found_value = WORD_BITS'(r_fval);
    assign o_occupancy   = r_occ;

    `RHH_ASSERT_NOW(a_cnt_bound, 1'b1, r_cnt <= CNT_W'(SLOTS), "entry count above capacity")
    `RHH_ASSERT_NEXT(a_resp_done, r_state == S_RESP, o_done && !busy, "response not strobed")
    `RHH_ASSERT_NOW(a_hash_state, w_hash_done, r_state == S_HASH, "hash finished out of turn")
    `RHH_ASSERT_NOW(a_done_full, o_done && o_status == STS_FULL,
        r_req == REQ_INSERT && o_occupancy == OCC_W'(SLOTS), "full reported below capacity")

endmodule

// ===== verif/robin_hood_hash_map_tb.sv =====
`timescale 1ns / 1ps

module robin_hood_hash_map_tb;
    import rhh_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int N_DIR      = 20;
    localparam int N_RAND     = 1580;
    localparam int N_TOTAL    = N_DIR + N_RAND;
    localparam int FILL_END   = N_DIR + 1200;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic [1:0]            status;
        logic [WORD_BITS-1:0]  value;
        logic [OCC_W-1:0]      occ;
    } t_answer;

    typedef struct {
        logic [1:0]            req;
        logic [KEY_BITS-1:0]   key;
        logic [WORD_BITS-1:0]  val;
        bit                    typed;
        t_answer               ans;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            i_req_type;
    logic [WORD_BITS-1:0]  i_key_word0;
    logic [WORD_BITS-1:0]  i_key_word1;
    logic [WORD_BITS-1:0]  i_key_word2;
    logic [WORD_BITS-1:0]  i_key_word3;
    logic [WORD_BITS-1:0]  i_new_value;
    logic                  o_done;
    logic [1:0]            o_status;
    logic [WORD_BITS-1:0]  o_found_value;
    logic [OCC_W-1:0]      o_occupancy;

    robin_hood_hash_map u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_key_word0   (i_key_word0),
        .i_key_word1   (i_key_word1),
        .i_key_word2   (i_key_word2),
        .i_key_word3   (i_key_word3),
        .i_new_value   (i_new_value),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_found_value (o_found_value),
        .o_occupancy   (o_occupancy)
    );

    // shadow table
    logic [KEY_BITS-1:0]   map_key [SLOTS];
    logic [VALUE_BITS-1:0] map_val [SLOTS];
    bit                    map_used[SLOTS];
    int                    map_dist[SLOTS];
    int                    map_count;

    t_row                  dir_tab[N_DIR];
    t_answer               answer_q[$];
    logic [KEY_BITS-1:0]   key_pool[$];
    int                    n_sent;
    int                    n_errors;
    int                    idle_cycles;
    int                    burst_left;
    int                    gap_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [WORD_BITS-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int home_slot(logic [KEY_BITS-1:0] k);
        logic [63:0] x;
        x = k[63:0] ^ k[127:64] ^ k[191:128] ^ k[255:192];
        x = x ^ (x >> MIX_SHIFT);
        x = x * MIX_MUL1;
        x = x ^ (x >> MIX_SHIFT);
        x = x * MIX_MUL2;
        x = x ^ (x >> MIX_SHIFT);
        return int'(x % SLOTS);
    endfunction

    function automatic int find_slot(logic [KEY_BITS-1:0] k);
        int p;
        p = home_slot(k);
        for (int d = 0; d < SLOTS; d++) begin
            if (!map_used[p] || map_dist[p] < d) return -1;
            if (map_key[p] == k) return p;
            p = (p + 1) % SLOTS;
        end
        return -1;
    endfunction

    task automatic place_entry(input logic [KEY_BITS-1:0] key, input logic [VALUE_BITS-1:0] val);
        logic [KEY_BITS-1:0]   k;
        logic [KEY_BITS-1:0]   tk;
        logic [VALUE_BITS-1:0] v;
        logic [VALUE_BITS-1:0] tv;
        int                    d;
        int                    td;
        int                    p;
        k = key;
        v = val;
        d = 0;
        p = home_slot(key);
        for (int s = 0; s < SLOTS; s++) begin
            if (!map_used[p]) begin
                map_key[p]  = k;
                map_val[p]  = v;
                map_dist[p] = d;
                map_used[p] = 1'b1;
                map_count++;
                return;
            end
            if (map_dist[p] < d) begin
                tk = map_key[p];
                tv = map_val[p];
                td = map_dist[p];
                map_key[p]  = k;
                map_val[p]  = v;
                map_dist[p] = d;
                k = tk;
                v = tv;
                d = td;
            end
            p = (p + 1) % SLOTS;
            d++;
        end
    endtask

    task automatic shift_back(input int at);
        int p;
        int n;
        p = at;
        for (int s = 0; s + 1 < SLOTS; s++) begin
            n = (p + 1) % SLOTS;
            if (!map_used[n] || map_dist[n] == 0) break;
            map_key[p]  = map_key[n];
            map_val[p]  = map_val[n];
            map_dist[p] = map_dist[n] - 1;
            map_used[p] = 1'b1;
            p = n;
        end
        map_key[p]  = '0;
        map_val[p]  = '0;
        map_dist[p] = 0;
        map_used[p] = 1'b0;
        if (map_count > 0) map_count--;
    endtask

    task automatic apply_request(input logic [1:0] req, input logic [KEY_BITS-1:0] k,
                                 input logic [WORD_BITS-1:0] v, output t_answer a);
        int at;
        a.status = STS_MISS;
        a.value  = '0;
        at = find_slot(k);
        case (req)
            REQ_INSERT: begin
                if (at >= 0) begin
                    map_val[at] = v[VALUE_BITS-1:0];
                    a.status = STS_OK;
                end else if (map_count >= SLOTS) begin
                    a.status = STS_FULL;
                end else begin
                    place_entry(k, v[VALUE_BITS-1:0]);
                    a.status = STS_OK;
                end
            end
            REQ_LOOKUP: begin
                if (at >= 0) begin
                    a.status = STS_OK;
                    a.value  = map_val[at];
                end
            end
            REQ_DELETE: begin
                if (at >= 0) begin
                    shift_back(at);
                    a.status = STS_OK;
                end
            end
            default: ;
        endcase
        a.occ = map_count[OCC_W-1:0];
    endtask

    task automatic make_key(input int mode, output logic [KEY_BITS-1:0] k);
        logic [KEY_BITS-1:0]  base;
        logic [WORD_BITS-1:0] m;
        int                   i;
        int                   j;
        if (mode == 0 || key_pool.size() == 0) begin
            k = {rand64(), rand64(), rand64(), rand64()};
            if ($urandom_range(0, 15) == 0)
                k[64*$urandom_range(0, 3) +: 64] = $urandom_range(0, 1) ? '1 : '0;
        end else begin
            base = key_pool[$urandom_range(0, key_pool.size() - 1)];
            k = base;
            if (mode == 2) begin
                // same word XOR, same home slot
                m = rand64();
                i = $urandom_range(0, 3);
                j = (i + $urandom_range(1, 3)) % 4;
                k[64*i +: 64] = k[64*i +: 64] ^ m;
                k[64*j +: 64] = k[64*j +: 64] ^ m;
            end
        end
    endtask

    task automatic make_item(output logic [1:0] req, output logic [KEY_BITS-1:0] k,
                             output logic [WORD_BITS-1:0] v);
        int r;
        int mode;
        r = $urandom_range(0, 99);
        if (n_sent < FILL_END && map_count < SLOTS) begin
            req  = (r < 85) ? REQ_INSERT : (r < 95) ? REQ_LOOKUP :
                   (r < 98) ? REQ_DELETE : REQ_UNUSED;
            r    = $urandom_range(0, 99);
            mode = (req == REQ_INSERT) ? ((r < 80) ? 0 : (r < 92) ? 2 : 1)
                                       : ((r < 70) ? 1 : (r < 85) ? 2 : 0);
        end else if (n_sent < FILL_END) begin
            req  = (r < 50) ? REQ_INSERT : (r < 85) ? REQ_LOOKUP :
                   (r < 95) ? REQ_DELETE : REQ_UNUSED;
            r    = $urandom_range(0, 99);
            mode = (r < 50) ? 1 : (r < 75) ? 2 : 0;
        end else begin
            req  = (r < 25) ? REQ_INSERT : (r < 55) ? REQ_LOOKUP :
                   (r < 98) ? REQ_DELETE : REQ_UNUSED;
            r    = $urandom_range(0, 99);
            mode = (r < 70) ? 1 : (r < 85) ? 2 : 0;
        end
        make_key(mode, k);
        r = $urandom_range(0, 15);
        v = (r == 0) ? '0 : (r == 1) ? '1 : rand64();
    endtask

    initial begin
        dir_tab[0]  = '{REQ_LOOKUP, '0, 64'd0, 1'b1, '{STS_MISS, 64'd0, 11'd0}};
        dir_tab[1]  = '{REQ_DELETE, '0, 64'd7, 1'b1, '{STS_MISS, 64'd0, 11'd0}};
        dir_tab[2]  = '{REQ_INSERT, '0, 64'd0, 1'b1, '{STS_OK, 64'd0, 11'd1}};
        dir_tab[3]  = '{REQ_INSERT, '1, '1, 1'b1, '{STS_OK, 64'd0, 11'd2}};
        dir_tab[4]  = '{REQ_LOOKUP, '0, 64'd0, 1'b1, '{STS_OK, 64'd0, 11'd2}};
        dir_tab[5]  = '{REQ_LOOKUP, '1, 64'd0, 1'b1, '{STS_OK, '1, 11'd2}};
        dir_tab[6]  = '{REQ_INSERT, '0, 64'h8000_0000_0000_0001, 1'b1,
                        '{STS_OK, 64'd0, 11'd2}};
        dir_tab[7]  = '{REQ_LOOKUP, '0, 64'd0, 1'b1,
                        '{STS_OK, 64'h8000_0000_0000_0001, 11'd2}};
        dir_tab[8]  = '{REQ_UNUSED, '1, '1, 1'b1, '{STS_MISS, 64'd0, 11'd2}};
        dir_tab[9]  = '{REQ_INSERT, {64'd0, 64'd0, 64'd1, 64'd1}, 64'd5, 1'b1,
                        '{STS_OK, 64'd0, 11'd3}};
        dir_tab[10] = '{REQ_INSERT, {{2{64'hfedcba9876543210}}, {2{64'h0123456789abcdef}}},
                        64'h55aa, 1'b1, '{STS_OK, 64'd0, 11'd4}};
        dir_tab[11] = '{REQ_LOOKUP, {64'd0, 64'd0, 64'd1, 64'd1}, 64'd0, 1'b1,
                        '{STS_OK, 64'd5, 11'd4}};
        dir_tab[12] = '{REQ_DELETE, '1, 64'd0, 1'b1, '{STS_OK, 64'd0, 11'd3}};
        dir_tab[13] = '{REQ_LOOKUP, {64'd0, 64'd0, 64'd1, 64'd1}, 64'd0, 1'b1,
                        '{STS_OK, 64'd5, 11'd3}};
        dir_tab[14] = '{REQ_LOOKUP, '1, 64'd0, 1'b1, '{STS_MISS, 64'd0, 11'd3}};
        dir_tab[15] = '{REQ_DELETE, '0, 64'd0, 1'b1, '{STS_OK, 64'd0, 11'd2}};
        dir_tab[16] = '{REQ_LOOKUP, {{2{64'hfedcba9876543210}}, {2{64'h0123456789abcdef}}},
                        64'd0, 1'b0, '{STS_OK, 64'd0, 11'd0}};
        dir_tab[17] = '{REQ_INSERT, {4{64'h5555_aaaa_3c3c_c3c3}}, 64'h8000_0000_0000_0000,
                        1'b0, '{STS_OK, 64'd0, 11'd0}};
        dir_tab[18] = '{REQ_LOOKUP, {4{64'h5555_aaaa_3c3c_c3c3}}, 64'd0, 1'b0,
                        '{STS_OK, 64'd0, 11'd0}};
        dir_tab[19] = '{REQ_UNUSED, '0, 64'h1234, 1'b1, '{STS_MISS, 64'd0, 11'd3}};
    end

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            map_key[s]  = '0;
            map_val[s]  = '0;
            map_used[s] = 1'b0;
            map_dist[s] = 0;
        end
        map_count   = 0;
        n_sent      = 0;
        n_errors    = 0;
        idle_cycles = 0;
        burst_left  = 0;
        gap_left    = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req_type  = REQ_LOOKUP;
        i_key_word0 = '0;
        i_key_word1 = '0;
        i_key_word2 = '0;
        i_key_word3 = '0;
        i_new_value = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (n_sent == N_TOTAL && answer_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        t_answer             exp_a;
        t_answer             got;
        logic [1:0]          req;
        logic [KEY_BITS-1:0] k;
        logic [WORD_BITS-1:0] v;
        bit                  took;
        if (i_rst_n) begin
            took = 1'b0;
            if (o_done) begin
                took = 1'b1;
                if (answer_q.size() == 0) begin
                    $display("%0t: unexpected transfer status=%0d value=%h occ=%0d",
                             $time, o_status, o_found_value, o_occupancy);
                    n_errors++;
                end else begin
                    exp_a = answer_q.pop_front();
                    if (o_status !== exp_a.status) begin
                        $display("%0t: status exp=%0d act=%0d", $time, exp_a.status, o_status);
                        n_errors++;
                    end
                    if (o_found_value !== exp_a.value) begin
                        $display("%0t: found_value exp=%h act=%h", $time, exp_a.value,
                                 o_found_value);
                        n_errors++;
                    end
                    if (o_occupancy !== exp_a.occ) begin
                        $display("%0t: occupancy exp=%0d act=%0d", $time, exp_a.occ,
                                 o_occupancy);
                        n_errors++;
                    end
                end
            end
            if (start && !busy) begin
                took = 1'b1;
                k = {i_key_word3, i_key_word2, i_key_word1, i_key_word0};
                apply_request(i_req_type, k, i_new_value, got);
                if (n_sent < N_DIR && dir_tab[n_sent].typed) got = dir_tab[n_sent].ans;
                answer_q.push_back(got);
                if (i_req_type == REQ_INSERT) key_pool.push_back(k);
                n_sent++;
            end
            idle_cycles = took ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
            if (!(start && busy)) begin
                if (n_sent >= N_TOTAL) begin
                    start <= 1'b0;
                end else if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else begin
                    if (n_sent < N_DIR) begin
                        req = dir_tab[n_sent].req;
                        k   = dir_tab[n_sent].key;
                        v   = dir_tab[n_sent].val;
                    end else begin
                        make_item(req, k, v);
                    end
                    start       <= 1'b1;
                    i_req_type  <= req;
                    i_key_word0 <= k[63:0];
                    i_key_word1 <= k[127:64];
                    i_key_word2 <= k[191:128];
                    i_key_word3 <= k[255:192];
                    i_new_value <= v;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                    end
                end
            end
        end
    end

endmodule
